>>> sv/pfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared constants, command type and bit helpers of the page frame allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

    localparam int NUM_WORDS   = 32768;
    localparam int PAGE_SHIFT  = 12;
    localparam int WORD_BITS   = 32;
    localparam int BIT_IDX_W   = 5;
    localparam int ADDR_W      = 32;
    // word index field of a frame address (bits 31..17)
    localparam int WIDX_W      = ADDR_W - PAGE_SHIFT - BIT_IDX_W;
    localparam int RANGE_W     = WIDX_W + 1;
    localparam int MEM_AW      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    // counts that must also hold NUM_WORDS itself
    localparam int CNT_W       = $clog2(NUM_WORDS + 1);

    localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic                 is_alloc;
        logic                 in_range;
        logic [WIDX_W-1:0]    word_idx;
        logic [BIT_IDX_W-1:0] bit_idx;
    } cmd_t;

    // index of the lowest clear bit; ~v & (v + 1) isolates it as a one-hot
    function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] onehot;
        logic [BIT_IDX_W-1:0] idx;
        onehot = ~v & (v + WORD_BITS'(1));
        idx    = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (onehot[i]) begin
                idx = idx | BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> sv/page_frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core
// First-fit 4 KiB page frame allocator over a bitmap, one bit per frame.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  request | req_valid / req_ready   | req_type, frame_address
//  result  | resp_valid / resp_ready | alloc_address, out_of_memory
//
//  A free, once the engine takes it, does a read, modify and write of one
//  bitmap word, then loads the result register.
//  An allocate scans words until it finds one with a clear bit. The bitmap
//  memory, with separate read and write ports, is walked one word per cycle
//  from the lowest word that may hold a clear bit up to the highest word
//  ever freed.
//  After reset a clearing pass fills the bitmap with ones; requests are
//  queued (two deep) but not executed until it ends.
//  The request side keeps accepting while the queue has room, also while a
//  result waits in the output register.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        req_type,
    input  logic [31:0] frame_address,
    output logic        resp_valid,
    input  logic        resp_ready,
    output logic [31:0] alloc_address,
    output logic        out_of_memory
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_not_empty;
    pfba_pkg::cmd_t push_cmd;
    pfba_pkg::cmd_t pop_cmd;

    pfba_front u_front (
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .frame_address (frame_address),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    pfba_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (pop_cmd),
        .not_empty (q_not_empty)
    );

    pfba_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .resp_valid    (resp_valid),
        .resp_ready    (resp_ready),
        .alloc_address (alloc_address),
        .out_of_memory (out_of_memory)
    );

endmodule

>>> sv/pfba_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_front
// Request intake: decodes each request into a command and pushes it to the queue.
// ----------------------------------------------------------------------------
module pfba_front (
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      req_type,
    input  logic [31:0]               frame_address,
    input  logic                      q_full,
    output logic                      q_push,
    output pfba_pkg::cmd_t            q_cmd
);

    logic [pfba_pkg::WIDX_W-1:0] word_idx;

    assign word_idx  = frame_address[pfba_pkg::ADDR_W-1 -: pfba_pkg::WIDX_W];
    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        q_cmd.is_alloc = (req_type == pfba_pkg::REQ_ALLOC);
        // frees past the end of the bitmap are dropped by the engine
        q_cmd.in_range = ({1'b0, word_idx} <
                          pfba_pkg::RANGE_W'(pfba_pkg::NUM_WORDS));
        q_cmd.word_idx = word_idx;
        q_cmd.bit_idx  = frame_address[pfba_pkg::PAGE_SHIFT +: pfba_pkg::BIT_IDX_W];
    end

endmodule

>>> sv/pfba_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_queue
// Short command FIFO between the request intake and the bitmap engine.
// ----------------------------------------------------------------------------
module pfba_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pfba_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output pfba_pkg::cmd_t pop_cmd,
    output logic           not_empty
);

    localparam logic [pfba_pkg::QPTR_W-1:0] LAST_PTR =
        pfba_pkg::QPTR_W'(pfba_pkg::QUEUE_DEPTH - 1);

    pfba_pkg::cmd_t                entry_reg [pfba_pkg::QUEUE_DEPTH];
    logic [pfba_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pfba_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pfba_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                          do_push, do_pop;

    assign full      = (cnt_reg == pfba_pkg::QCNT_W'(pfba_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + pfba_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + pfba_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + pfba_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - pfba_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/pfba_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_engine
// Bitmap engine: owns the frame bitmap memory, runs frees and first-fit scans.
// ----------------------------------------------------------------------------
module pfba_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  pfba_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           resp_valid,
    input  logic           resp_ready,
    output logic [31:0]    alloc_address,
    output logic           out_of_memory
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE_MOD,
        ST_SCAN,
        ST_RESP
    } state_t;

    localparam int MAW = pfba_pkg::MEM_AW;
    localparam int CW  = pfba_pkg::CNT_W;
    localparam int WB  = pfba_pkg::WORD_BITS;

    localparam logic [MAW-1:0] LAST_WORD = MAW'(pfba_pkg::NUM_WORDS - 1);
    localparam logic [CW-1:0]  WORDS_CNT = CW'(pfba_pkg::NUM_WORDS);

    state_t             state_reg, state_next;
    logic [MAW-1:0]     clr_reg, clr_next;
    // words below hint and from top upward are known to be full
    logic [CW-1:0]      hint_reg, hint_next;
    logic [CW-1:0]      top_reg, top_next;
    logic [CW-1:0]      chk_reg, chk_next;
    pfba_pkg::cmd_t     cmd_reg, cmd_next;
    logic [31:0]        res_addr_reg, res_addr_next;
    logic               res_oom_reg, res_oom_next;
    logic               resp_valid_reg, resp_valid_next;
    logic [31:0]        alloc_address_reg, alloc_address_next;
    logic               out_of_memory_reg, out_of_memory_next;

    logic [WB-1:0]      mem [pfba_pkg::NUM_WORDS];
    logic [WB-1:0]      rd_data_reg;
    logic               mem_we, mem_re;
    logic [MAW-1:0]     mem_wa, mem_ra;
    logic [WB-1:0]      mem_wd;

    logic [CW-1:0]      scan_next;
    logic [CW-1:0]      free_word;
    logic [CW-1:0]      free_top;
    logic               found;
    logic [WB-1:0]      set_word;

    assign scan_next = chk_reg + CW'(1);
    assign free_word = CW'(cmd_reg.word_idx);
    assign free_top  = free_word + CW'(1);
    assign found     = (rd_data_reg != pfba_pkg::FULL_WORD);
    assign set_word  = rd_data_reg | (rd_data_reg + WB'(1));

    always_comb
    begin
        state_next         = state_reg;
        clr_next           = clr_reg;
        hint_next          = hint_reg;
        top_next           = top_reg;
        chk_next           = chk_reg;
        cmd_next           = cmd_reg;
        res_addr_next      = res_addr_reg;
        res_oom_next       = res_oom_reg;
        resp_valid_next    = resp_valid_reg;
        alloc_address_next = alloc_address_reg;
        out_of_memory_next = out_of_memory_reg;
        mem_we             = 1'b0;
        mem_wa             = clr_reg;
        mem_wd             = pfba_pkg::FULL_WORD;
        mem_re             = 1'b0;
        mem_ra             = scan_next[MAW-1:0];
        q_pop              = 1'b0;

        if (resp_valid_reg && resp_ready) begin
            resp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep the whole bitmap to all ones after reset
                mem_we   = 1'b1;
                clr_next = clr_reg + MAW'(1);
                if (clr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    if (!q_cmd.is_alloc) begin
                        if (q_cmd.in_range) begin
                            mem_re     = 1'b1;
                            mem_ra     = q_cmd.word_idx[MAW-1:0];
                            state_next = ST_FREE_MOD;
                        end else begin
                            res_addr_next = '0;
                            res_oom_next  = 1'b0;
                            state_next    = ST_RESP;
                        end
                    end else if (hint_reg >= top_reg) begin
                        res_addr_next = '0;
                        res_oom_next  = 1'b1;
                        state_next    = ST_RESP;
                    end else begin
                        mem_re     = 1'b1;
                        mem_ra     = hint_reg[MAW-1:0];
                        chk_next   = hint_reg;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FREE_MOD:
            begin
                mem_we        = 1'b1;
                mem_wa        = cmd_reg.word_idx[MAW-1:0];
                mem_wd        = rd_data_reg & ~(WB'(1) << cmd_reg.bit_idx);
                hint_next     = (free_word < hint_reg) ? free_word : hint_reg;
                top_next      = (free_top > top_reg) ? free_top : top_reg;
                res_addr_next = '0;
                res_oom_next  = 1'b0;
                state_next    = ST_RESP;
            end
            ST_SCAN:
            begin
                // read the following word while checking this one
                mem_re = (scan_next < top_reg);
                if (found) begin
                    mem_we        = 1'b1;
                    mem_wa        = chk_reg[MAW-1:0];
                    mem_wd        = set_word;
                    res_addr_next = {pfba_pkg::WIDX_W'(chk_reg),
                                     pfba_pkg::lowest_zero(rd_data_reg),
                                     {pfba_pkg::PAGE_SHIFT{1'b0}}};
                    res_oom_next  = 1'b0;
                    hint_next     = (set_word == pfba_pkg::FULL_WORD) ? scan_next : chk_reg;
                    state_next    = ST_RESP;
                end else if (scan_next >= top_reg) begin
                    hint_next     = top_reg;
                    res_addr_next = '0;
                    res_oom_next  = 1'b1;
                    state_next    = ST_RESP;
                end else begin
                    chk_next = scan_next;
                end
            end
            ST_RESP:
            begin
                if (!resp_valid_reg || resp_ready) begin
                    resp_valid_next    = 1'b1;
                    alloc_address_next = res_addr_reg;
                    out_of_memory_next = res_oom_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= ST_CLEAR;
            clr_reg           <= '0;
            hint_reg          <= WORDS_CNT;
            top_reg           <= '0;
            chk_reg           <= '0;
            cmd_reg           <= '0;
            res_addr_reg      <= '0;
            res_oom_reg       <= 1'b0;
            resp_valid_reg    <= 1'b0;
            alloc_address_reg <= '0;
            out_of_memory_reg <= 1'b0;
        end else begin
            state_reg         <= state_next;
            clr_reg           <= clr_next;
            hint_reg          <= hint_next;
            top_reg           <= top_next;
            chk_reg           <= chk_next;
            cmd_reg           <= cmd_next;
            res_addr_reg      <= res_addr_next;
            res_oom_reg       <= res_oom_next;
            resp_valid_reg    <= resp_valid_next;
            alloc_address_reg <= alloc_address_next;
            out_of_memory_reg <= out_of_memory_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign resp_valid    = resp_valid_reg;
    assign alloc_address = alloc_address_reg;
    assign out_of_memory = out_of_memory_reg;

    // a failed allocate always reports address zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid_reg && out_of_memory_reg) |-> (alloc_address_reg == '0))
        else $error("out_of_memory with nonzero address");

    // a scan never looks outside the window that may hold clear bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (chk_reg >= hint_reg && chk_reg < top_reg))
        else $error("scan pointer outside hint/top window");

    // nothing is taken from the queue while the bitmap is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!q_pop && !mem_re))
        else $error("command taken during clearing pass");

    // a completed scan hit leaves the hint at or below the word after the allocated one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && found) |=> (hint_reg <= $past(scan_next)))
        else $error("hint moved past allocated word");

endmodule

>>> tb/sv/pfba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_checker
// Watches the request and result channels of the page frame allocator.
// Keeps its own copy of the frame bitmap. For each request transfer it
// predicts the grant (address and out-of-memory flag), queues it, and
// compares every result transfer against the oldest queued grant.
// ----------------------------------------------------------------------------
module pfba_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        req_type,
    input  logic [pfba_pkg::ADDR_W-1:0] frame_address,
    input  logic                        resp_valid,
    input  logic                        resp_ready,
    input  logic [pfba_pkg::ADDR_W-1:0] alloc_address,
    input  logic                        out_of_memory,
    output int                          fail_count,
    output int                          pending_grants,
    output int                          alloc_count,
    output int                          free_count,
    output int                          oom_count
);

    typedef struct packed {
        logic [pfba_pkg::ADDR_W-1:0] addr;
        logic                        oom;
    } grant_t;

    logic [pfba_pkg::WORD_BITS-1:0] frame_busy [pfba_pkg::NUM_WORDS];
    int                             top_freed_word;
    grant_t                         expected_grants[$];
    int                             mismatches;
    int                             allocs;
    int                             frees;
    int                             ooms;

    assign fail_count  = mismatches;
    assign alloc_count = allocs;
    assign free_count  = frees;
    assign oom_count   = ooms;

    initial
    begin
        for (int w = 0; w < pfba_pkg::NUM_WORDS; w++)
        begin
            frame_busy[w] = pfba_pkg::FULL_WORD;
        end
        top_freed_word = -1;
        mismatches     = 0;
        allocs         = 0;
        frees          = 0;
        ooms           = 0;
    end

    task automatic report_mismatch(input string what,
                                   input logic [pfba_pkg::ADDR_W-1:0] got,
                                   input logic [pfba_pkg::ADDR_W-1:0] want);
        $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one request to the bitmap copy and return the grant it yields.
    function automatic grant_t predict_grant(input logic kind,
                                             input logic [pfba_pkg::ADDR_W-1:0] addr);
        grant_t g;
        int     word_idx;
        g.addr = '0;
        g.oom  = 1'b0;
        if (kind == pfba_pkg::REQ_FREE)
        begin
            word_idx = int'(addr[pfba_pkg::ADDR_W-1:pfba_pkg::PAGE_SHIFT+pfba_pkg::BIT_IDX_W]);
            if (word_idx < pfba_pkg::NUM_WORDS)
            begin
                frame_busy[word_idx][addr[pfba_pkg::PAGE_SHIFT+pfba_pkg::BIT_IDX_W-1:
                                          pfba_pkg::PAGE_SHIFT]] = 1'b0;
                if (word_idx > top_freed_word)
                begin
                    top_freed_word = word_idx;
                end
            end
            return g;
        end
        // words above the highest one ever freed are still all ones
        g.oom = 1'b1;
        for (int w = 0; w <= top_freed_word && g.oom; w++)
        begin
            if (frame_busy[w] != pfba_pkg::FULL_WORD)
            begin
                for (int b = 0; b < pfba_pkg::WORD_BITS && g.oom; b++)
                begin
                    if (!frame_busy[w][b])
                    begin
                        frame_busy[w][b] = 1'b1;
                        g.addr = (pfba_pkg::ADDR_W'(w) * pfba_pkg::WORD_BITS +
                                  pfba_pkg::ADDR_W'(b)) << pfba_pkg::PAGE_SHIFT;
                        g.oom  = 1'b0;
                    end
                end
            end
        end
        return g;
    endfunction

    always @(posedge clk)
    begin : watch
        grant_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_grants.push_back(predict_grant(req_type, frame_address));
                if (req_type == pfba_pkg::REQ_FREE)
                begin
                    frees++;
                end
                else
                begin
                    allocs++;
                end
            end
            if (resp_valid && resp_ready)
            begin
                if (out_of_memory === 1'b1)
                begin
                    ooms++;
                end
                if (expected_grants.size() == 0)
                begin
                    report_mismatch("result with nothing pending", alloc_address, '0);
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (alloc_address !== want.addr)
                    begin
                        report_mismatch("alloc_address", alloc_address, want.addr);
                    end
                    if (out_of_memory !== want.oom)
                    begin
                        report_mismatch("out_of_memory",
                                        pfba_pkg::ADDR_W'(out_of_memory),
                                        pfba_pkg::ADDR_W'(want.oom));
                    end
                end
            end
            pending_grants <= expected_grants.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the page frame allocator. Runs directed frees and
// allocations around frame zero and word boundaries, random free/allocate
// mixes in the low words, a drain to out-of-memory, then frees of frames in
// the top words and scans that walk across all the full words below them.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT = 250000;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        req_valid     = 1'b0;
    logic                        req_type      = pfba_pkg::REQ_ALLOC;
    logic [pfba_pkg::ADDR_W-1:0] frame_address = '0;
    logic                        resp_ready    = 1'b0;
    logic                        req_ready;
    logic                        resp_valid;
    logic [pfba_pkg::ADDR_W-1:0] alloc_address;
    logic                        out_of_memory;

    int fail_count;
    int pending_grants;
    int alloc_count;
    int free_count;
    int oom_count;
    int quiet_cycles = 0;
    int ready_hold   = 0;
    bit steady       = 1'b0;

    always #4 clk = ~clk;

    page_frame_bitmap_allocator_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .frame_address (frame_address),
        .resp_valid    (resp_valid),
        .resp_ready    (resp_ready),
        .alloc_address (alloc_address),
        .out_of_memory (out_of_memory)
    );

    pfba_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .frame_address  (frame_address),
        .resp_valid     (resp_valid),
        .resp_ready     (resp_ready),
        .alloc_address  (alloc_address),
        .out_of_memory  (out_of_memory),
        .fail_count     (fail_count),
        .pending_grants (pending_grants),
        .alloc_count    (alloc_count),
        .free_count     (free_count),
        .oom_count      (oom_count)
    );

    // Result side: random ready pattern, mostly short stalls, a few long ones.
    always @(posedge clk)
    begin : result_side
        int pick;
        if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (steady)
        begin
            resp_ready <= 1'b1;
            ready_hold <= 8;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                resp_ready <= 1'b1;
                ready_hold <= $urandom_range(0, 4);
            end
            else if (pick < 90)
            begin
                resp_ready <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end
            else
            begin
                resp_ready <= 1'b0;
                ready_hold <= $urandom_range(10, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (resp_valid && resp_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("no transfer for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60)
        begin
            return 0;
        end
        if (pick < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Frame in the low words only, so allocation scans stay short.
    function automatic logic [pfba_pkg::ADDR_W-1:0] low_frame_addr();
        int word_idx;
        word_idx = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : $urandom_range(0, 7);
        return {15'(word_idx), 5'($urandom()), 12'($urandom())};
    endfunction

    task automatic issue_request(input logic kind, input logic [pfba_pkg::ADDR_W-1:0] addr);
        int gap;
        req_valid     <= 1'b1;
        req_type      <= kind;
        frame_address <= addr;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the request side until every predicted grant has come back.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int oom_mark;
        int rounds;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty bitmap, frame zero, double free, word boundaries
        issue_request(pfba_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(pfba_pkg::REQ_ALLOC, 32'hFFFF_FFFF);
        issue_request(pfba_pkg::REQ_FREE,  32'h0000_0FFF);
        issue_request(pfba_pkg::REQ_FREE,  32'h0000_0000);
        issue_request(pfba_pkg::REQ_ALLOC, 32'h5555_5555);
        issue_request(pfba_pkg::REQ_ALLOC, 32'hAAAA_AAAA);
        issue_request(pfba_pkg::REQ_FREE,  32'h0001_F000);
        issue_request(pfba_pkg::REQ_FREE,  32'h0002_0ABC);
        issue_request(pfba_pkg::REQ_FREE,  32'h0000_1000);
        issue_request(pfba_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(pfba_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(pfba_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(pfba_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(pfba_pkg::REQ_FREE,  32'h000F_FFFF);
        issue_request(pfba_pkg::REQ_FREE,  32'h0000_5555);
        issue_request(pfba_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(pfba_pkg::REQ_ALLOC, 32'h0000_0000);
        issue_request(pfba_pkg::REQ_ALLOC, 32'h0000_0000);
        settle();

        // alternate free-heavy and allocate-heavy stretches
        for (int blk = 0; blk < 16; blk++)
        begin
            steady = (blk % 5 == 4);
            repeat (40)
            begin
                if ($urandom_range(0, 99) < ((blk % 2 == 0) ? 70 : 25))
                begin
                    issue_request(pfba_pkg::REQ_FREE, low_frame_addr());
                end
                else
                begin
                    issue_request(pfba_pkg::REQ_ALLOC, $urandom());
                end
            end
            if (blk % 4 == 3)
            begin
                settle();
            end
        end
        steady = 1'b0;
        settle();

        // drain the low words until allocation fails
        rounds = 0;
        do
        begin
            oom_mark = oom_count;
            repeat (16) issue_request(pfba_pkg::REQ_ALLOC, $urandom());
            settle();
            rounds++;
        end
        while (oom_count == oom_mark && rounds < 20);

        // frees high in the bitmap: each allocation walks the full words below
        issue_request(pfba_pkg::REQ_FREE, 32'hFFFF_FFFF);
        issue_request(pfba_pkg::REQ_FREE, 32'hFFFF_E000);
        issue_request(pfba_pkg::REQ_FREE, 32'h8000_0123);
        issue_request(pfba_pkg::REQ_FREE, 32'h7FFE_0FFF);
        issue_request(pfba_pkg::REQ_FREE,
                      {15'($urandom_range(8, pfba_pkg::NUM_WORDS - 1)), 5'($urandom()),
                       12'($urandom())});
        issue_request(pfba_pkg::REQ_FREE, 32'hFFFF_FFFF);
        repeat (6) issue_request(pfba_pkg::REQ_ALLOC, $urandom());
        settle();
        repeat (40) @(posedge clk);

        $display("covered %0d allocate and %0d free transfers, %0d out-of-memory results",
                 alloc_count, free_count, oom_count);
        $display("including double frees, frame zero, and scans up to the top bitmap word");
        if (fail_count == 0 && pending_grants == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
